[rtl/core/icy_pkg.sv]
package icy_pkg;

  // Metadata bytes per metadata length unit
  localparam int unsigned META_UNIT  = 16;
  localparam int unsigned UNIT_SHIFT = $clog2(META_UNIT);

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned META_W     = 12;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;

  // Configuration register indexes
  typedef enum logic {
    REG_INTERVAL = 1'b0,
    REG_SKIP     = 1'b1
  } reg_index_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_AUDIO    = 2'd1,
    KIND_META     = 2'd2,
    KIND_META_END = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] out_byte;
    logic              metadata_done;
    logic              chunk_flush;
  } result_t;

endpackage

[rtl/core/icy_in_if.sv]
interface icy_in_if;
  logic                          valid;
  logic                          ready;
  logic [icy_pkg::BYTE_W-1:0]    in_byte;
  logic                          chunk_end;

  modport source (output valid, output in_byte, output chunk_end, input ready);
  modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

[rtl/core/icy_out_if.sv]
interface icy_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [icy_pkg::BYTE_W-1:0]    out_byte;
  logic                          metadata_done;
  logic                          chunk_flush;

  modport source (output valid, output kind, output out_byte, output metadata_done,
                  output chunk_flush, input ready);
  modport sink   (input valid, input kind, input out_byte, input metadata_done,
                  input chunk_flush, output ready);
endinterface

[rtl/core/icy_hdr.sv]
module icy_hdr (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [icy_pkg::BYTE_W-1:0] in_byte,
  input  logic                       rearm,
  input  logic                       skip,
  output logic                       header_done
);

  logic saw_cr;
  logic line_started;
  logic cur_empty;

  logic header_done_next;
  logic saw_cr_next;
  logic line_started_next;
  logic cur_empty_next;

  // Track CR-LF line breaks until the blank line that ends the header
  always_comb begin
    header_done_next  = header_done;
    saw_cr_next       = saw_cr;
    line_started_next = line_started;
    cur_empty_next    = cur_empty;
    if (rearm) begin
      header_done_next  = ~skip;
      saw_cr_next       = 1'b0;
      line_started_next = 1'b0;
      cur_empty_next    = 1'b1;
    end else if (push && !header_done) begin
      if (saw_cr && in_byte == icy_pkg::CH_LF) begin
        saw_cr_next = 1'b0;
        if (line_started && cur_empty) begin
          header_done_next = 1'b1;
        end else begin
          line_started_next = 1'b1;
          cur_empty_next    = 1'b1;
        end
      end else if (in_byte == icy_pkg::CH_CR) begin
        saw_cr_next = 1'b1;
      end else begin
        saw_cr_next = 1'b0;
        if (line_started) begin
          cur_empty_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_done  <= 1'b1;
      saw_cr       <= 1'b0;
      line_started <= 1'b0;
      cur_empty    <= 1'b1;
    end else begin
      header_done  <= header_done_next;
      saw_cr       <= saw_cr_next;
      line_started <= line_started_next;
      cur_empty    <= cur_empty_next;
    end
  end

endmodule

[rtl/core/icy_body.sv]
module icy_body (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic                           header_done,
  input  logic [icy_pkg::INTERVAL_W-1:0] interval,
  input  logic [icy_pkg::BYTE_W-1:0]     in_byte,
  input  logic                           chunk_end,
  output icy_pkg::result_t               result
);

  logic [icy_pkg::INTERVAL_W-1:0] audio_count;
  logic [icy_pkg::META_W-1:0]     meta_remaining;
  logic                           meta_has_text;

  logic [icy_pkg::INTERVAL_W-1:0] audio_count_next;
  logic [icy_pkg::META_W-1:0]     meta_remaining_next;
  logic                           meta_has_text_next;

  logic                           printable;
  logic [icy_pkg::META_W-1:0]     meta_len;

  assign printable = (in_byte >= icy_pkg::PRINT_LO) && (in_byte <= icy_pkg::PRINT_HI);
  assign meta_len  = icy_pkg::META_W'({in_byte, icy_pkg::UNIT_SHIFT'(0)});

  // Split body bytes into audio, length bytes and metadata text
  always_comb begin
    audio_count_next     = audio_count;
    meta_remaining_next  = meta_remaining;
    meta_has_text_next   = meta_has_text;
    result.kind          = icy_pkg::KIND_NONE;
    result.out_byte      = '0;
    result.metadata_done = 1'b0;
    result.chunk_flush   = chunk_end;
    if (header_done) begin
      if (meta_remaining != '0) begin
        meta_remaining_next = meta_remaining - icy_pkg::META_W'(1);
        if (printable) begin
          result.kind        = icy_pkg::KIND_META;
          result.out_byte    = in_byte;
          meta_has_text_next = 1'b1;
        end
        if (meta_remaining_next == '0) begin
          audio_count_next   = '0;
          meta_has_text_next = 1'b0;
          if (meta_has_text || printable) begin
            result.metadata_done = 1'b1;
            if (!printable) begin
              result.kind = icy_pkg::KIND_META_END;
            end
          end
        end
      end else if (interval != '0 && audio_count == interval) begin
        meta_remaining_next = meta_len;
        if (meta_len == '0) begin
          audio_count_next = '0;
        end
      end else begin
        audio_count_next = audio_count + icy_pkg::INTERVAL_W'(1);
        result.kind      = icy_pkg::KIND_AUDIO;
        result.out_byte  = in_byte;
      end
    end
  end

  // Advance the counters only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      audio_count    <= '0;
      meta_remaining <= '0;
      meta_has_text  <= 1'b0;
    end else if (push) begin
      audio_count    <= audio_count_next;
      meta_remaining <= meta_remaining_next;
      meta_has_text  <= meta_has_text_next;
    end
  end

endmodule

[rtl/core/icy_out_buf.sv]
module icy_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  icy_pkg::result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output icy_pkg::result_t out_data
);

  logic             main_valid;
  logic             skid_valid;
  icy_pkg::result_t main_data;
  icy_pkg::result_t skid_data;
  logic             pop;

  assign pop       = main_valid && out_ready;
  assign can_push  = ~skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // Hold results in a main register and one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop && skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push && (!main_valid || pop)) begin
        main_valid <= 1'b1;
      end else if (push) begin
        skid_valid <= 1'b1;
      end else if (pop) begin
        main_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      main_data <= skid_data;
    end else if (push && (!main_valid || pop)) begin
      main_data <= push_data;
    end
    if (push && main_valid && !pop) begin
      skid_data <= push_data;
    end
  end

  // The skid entry is only ever filled behind a full main register
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry valid while main register empty");

  // A result that is not taken stays offered
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (main_valid && !out_ready) |=> main_valid)
    else $error("stalled result dropped");

  // A request arriving behind a stalled result lands in the skid entry
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (push && main_valid && !out_ready) |=> skid_valid)
    else $error("request lost behind stalled result");

endmodule

[rtl/core/icy_metadata_demux.sv]
// ICY metadata demultiplexer.
// in_chan carries raw response bytes (in_byte, chunk_end); out_chan returns
// exactly one result per accepted byte: kind (none, audio, metadata char,
// metadata end), out_byte, metadata_done and chunk_flush, in input order.
// Configuration: cfg_we with cfg_index selects metadata_interval (0) or
// skip_icy_header (1); writing skip_icy_header rearms the header tracker.
// Write configuration only while no result is outstanding.
// Each accepted byte's result is registered in the result register, or in
// the skid entry while that register is held. Throughput: one byte per
// cycle while in_chan.ready is high; the per-byte work is a compare and a
// 16-bit counter update ahead of the result register.
// Stalls: a two-entry output buffer (result register plus one skid entry)
// keeps accepting while one result waits; in_chan.ready drops only when
// both entries are full.
// Reset (rst, synchronous): interval 0, header skipping off, counters
// cleared, output buffer empty.
module icy_metadata_demux (
  input  logic                           clk,
  input  logic                           rst,
  icy_in_if.sink                         in_chan,
  icy_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [icy_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [icy_pkg::INTERVAL_W-1:0] interval;
  logic                           push;
  logic                           can_push;
  logic                           rearm;
  logic                           header_done;
  icy_pkg::result_t               result;
  icy_pkg::result_t               out_data;

  assign push  = in_chan.valid && can_push;
  assign rearm = cfg_we && (cfg_index == icy_pkg::REG_SKIP);
  assign in_chan.ready = can_push;

  // Interval register; the skip bit only loads the header tracker on rearm
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= '0;
    end else if (cfg_we && (cfg_index == icy_pkg::REG_INTERVAL)) begin
      interval <= cfg_data[icy_pkg::INTERVAL_W-1:0];
    end
  end

  icy_hdr u_hdr (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .in_byte     (in_chan.in_byte),
    .rearm       (rearm),
    .skip        (cfg_data[0]),
    .header_done (header_done)
  );

  icy_body u_body (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .header_done (header_done),
    .interval    (interval),
    .in_byte     (in_chan.in_byte),
    .chunk_end   (in_chan.chunk_end),
    .result      (result)
  );

  icy_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .can_push  (can_push),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_data)
  );

  // Drive the result channel
  assign out_chan.kind          = out_data.kind;
  assign out_chan.out_byte      = out_data.out_byte;
  assign out_chan.metadata_done = out_data.metadata_done;
  assign out_chan.chunk_flush   = out_data.chunk_flush;

endmodule

[tb/icy_metadata_demux_tb.sv]
module icy_metadata_demux_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import icy_pkg::*;

  localparam int NPHASE      = 8;
  localparam int PHASE_ITEMS = 60;
  localparam int WRAP_ITEMS  = 64;

  // One directed step: a register write or a run of identical requests
  typedef struct packed {
    logic                  wr;
    reg_index_t            idx;
    logic [CFG_DATA_W-1:0] data;
    logic [BYTE_W-1:0]     b;
    logic                  ce;
    logic [4:0]            reps;
    logic                  typed;
    result_t               want;
  } step_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  icy_in_if  in_ch ();
  icy_out_if out_ch ();

  icy_metadata_demux i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Demux state as the block should hold it
  logic                  skip_hdr;
  logic [INTERVAL_W-1:0] meta_interval;
  logic                  hdr_done;
  logic                  cr_seen;
  logic                  line_open;
  logic                  line_blank;
  logic                  prev_blank;
  logic [INTERVAL_W-1:0] audio_cnt;
  logic [META_W-1:0]     meta_left;
  logic                  meta_text;

  result_t demux_results_q[$];
  int      fail_cnt = 0;
  int      idle_pct = 30;
  int      blk_style = 0;
  logic    want_big = 1'b0;
  step_t   plan[$];

  logic [CFG_DATA_W-1:0] ph_interval [NPHASE] =
    '{16'd3, 16'd1, 16'd0, 16'hFFFF, 16'd2, 16'd16, 16'd5, 16'd1};
  logic                  ph_skip [NPHASE] =
    '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

  // Work out the result of one byte and advance the demux state
  function automatic result_t demux_byte(input logic [BYTE_W-1:0] b, input logic ce);
    result_t r;
    logic    printable;
    r.kind          = KIND_NONE;
    r.out_byte      = '0;
    r.metadata_done = 1'b0;
    r.chunk_flush   = ce;
    printable       = (b >= PRINT_LO) && (b <= PRINT_HI);
    if (!hdr_done) begin
      if (cr_seen && b == CH_LF) begin
        cr_seen = 1'b0;
        if (line_open && line_blank) begin
          hdr_done = 1'b1;
        end else begin
          prev_blank = line_blank;
          line_open  = 1'b1;
          line_blank = 1'b1;
        end
      end else if (b == CH_CR) begin
        cr_seen = 1'b1;
      end else begin
        cr_seen = 1'b0;
        if (line_open) line_blank = 1'b0;
      end
    end else if (meta_left != 0) begin
      meta_left = meta_left - 1'b1;
      if (printable) begin
        r.kind     = KIND_META;
        r.out_byte = b;
        meta_text  = 1'b1;
      end
      if (meta_left == 0) begin
        audio_cnt = '0;
        if (meta_text) begin
          r.metadata_done = 1'b1;
          if (r.kind == KIND_NONE) r.kind = KIND_META_END;
        end
        meta_text = 1'b0;
      end
    end else if (meta_interval != 0 && audio_cnt == meta_interval) begin
      // length byte: counts units of metadata
      meta_left = META_W'(b * META_UNIT);
      if (meta_left == 0) audio_cnt = '0;
    end else begin
      audio_cnt  = audio_cnt + 1'b1;
      r.kind     = KIND_AUDIO;
      r.out_byte = b;
    end
    return r;
  endfunction

  function automatic step_t reg_row(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    step_t s;
    s      = '0;
    s.wr   = 1'b1;
    s.idx  = idx;
    s.data = data;
    return s;
  endfunction

  function automatic step_t byte_row(input logic [BYTE_W-1:0] b, input logic ce,
                                     input logic [4:0] reps);
    step_t s;
    s      = '0;
    s.b    = b;
    s.ce   = ce;
    s.reps = reps;
    return s;
  endfunction

  function automatic step_t fixed_row(input logic [BYTE_W-1:0] b, input logic ce,
                                      input kind_t k, input logic [BYTE_W-1:0] ob,
                                      input logic done);
    step_t s;
    s       = byte_row(b, ce, 5'd1);
    s.typed = 1'b1;
    s.want  = '{kind: k, out_byte: ob, metadata_done: done, chunk_flush: ce};
    return s;
  endfunction

  function automatic logic chunk_mark();
    return ($urandom_range(9) == 0);
  endfunction

  function automatic logic [BYTE_W-1:0] header_char();
    case ($urandom_range(9))
      0:       return CH_LF;
      1:       return BYTE_W'($urandom_range(255));
      default: return BYTE_W'($urandom_range(126, 32));
    endcase
  endfunction

  function automatic void report_diff(input string field, input int want, input int got);
    fail_cnt++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endfunction

  // Offer one request with random gaps ahead of it, record its result on acceptance
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic ce,
                           input logic typed = 1'b0, input result_t want = '0);
    result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_byte   <= b;
    in_ch.chunk_end <= ce;
    do @(posedge clk); while (!in_ch.ready);
    r = demux_byte(b, ce);
    demux_results_q = {demux_results_q, (typed ? want : r)};
  endtask

  // Hold off requests until every result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (demux_results_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_INTERVAL) begin
      meta_interval = data;
    end else begin
      // header tracking rearms, body counters stay
      skip_hdr   = data[0];
      hdr_done   = !data[0];
      cr_seen    = 1'b0;
      line_open  = 1'b0;
      line_blank = 1'b1;
      prev_blank = 1'b0;
    end
  endtask

  // Status line, a few field lines, then the blank line that ends the header
  task automatic send_header();
    repeat ($urandom_range(6)) send_byte(header_char(), chunk_mark());
    send_byte(CH_CR, chunk_mark());
    send_byte(CH_LF, chunk_mark());
    repeat ($urandom_range(3)) begin
      repeat ($urandom_range(8, 1)) send_byte(header_char(), chunk_mark());
      // broken line ending: doubled CR
      if ($urandom_range(3) == 0) send_byte(CH_CR, chunk_mark());
      send_byte(CH_CR, chunk_mark());
      send_byte(CH_LF, chunk_mark());
    end
    while (!hdr_done) begin
      send_byte(CH_CR, chunk_mark());
      send_byte(CH_LF, chunk_mark());
    end
  endtask

  // Pick a body byte that fits where the stream stands
  task automatic send_body_byte();
    logic [BYTE_W-1:0] b;
    int                x;
    if (meta_left != 0) begin
      case (blk_style)
        0: b = ($urandom_range(99) < 85) ? BYTE_W'($urandom_range(126, 32))
                                         : BYTE_W'($urandom_range(255));
        1: begin
          // control or high byte only
          x = $urandom_range(160);
          b = (x < 32) ? BYTE_W'(x) : BYTE_W'(x + 95);
        end
        default: b = BYTE_W'($urandom_range(255));
      endcase
    end else if (meta_interval != 0 && audio_cnt == meta_interval) begin
      blk_style = $urandom_range(2);
      x         = $urandom_range(99);
      if (want_big) begin
        b        = 8'h08;
        want_big = 1'b0;
      end else if (x < 15) begin
        b = 8'h00;
      end else if (x < 75) begin
        b = 8'h01;
      end else if (x < 92) begin
        b = 8'h02;
      end else begin
        b = BYTE_W'($urandom_range(6, 3));
      end
    end else begin
      b = BYTE_W'($urandom_range(255));
    end
    send_byte(b, chunk_mark());
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drop ready at random, except while idle_pct is zero
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Compare each returned result with the oldest one pending
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (demux_results_q.size() == 0) begin
        report_diff("unexpected result, kind", -1, int'(out_ch.kind));
      end else begin
        want = demux_results_q.pop_front();
        if (out_ch.kind !== want.kind)
          report_diff("kind", int'(want.kind), int'(out_ch.kind));
        if (out_ch.out_byte !== want.out_byte)
          report_diff("out_byte", int'(want.out_byte), int'(out_ch.out_byte));
        if (out_ch.metadata_done !== want.metadata_done)
          report_diff("metadata_done", int'(want.metadata_done), int'(out_ch.metadata_done));
        if (out_ch.chunk_flush !== want.chunk_flush)
          report_diff("chunk_flush", int'(want.chunk_flush), int'(out_ch.chunk_flush));
      end
    end
  end

  initial begin
    int body_n;

    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.in_byte   <= '0;
    in_ch.chunk_end <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_INTERVAL;
    cfg_data        <= '0;

    skip_hdr      = 1'b0;
    meta_interval = '0;
    hdr_done      = 1'b1;
    cr_seen       = 1'b0;
    line_open     = 1'b0;
    line_blank    = 1'b1;
    prev_blank    = 1'b0;
    audio_cnt     = '0;
    meta_left     = '0;
    meta_text     = 1'b0;

    plan = '{
      // after reset every byte is audio
      fixed_row(8'h00, 1'b0, KIND_AUDIO, 8'h00, 1'b0),
      fixed_row(8'hFF, 1'b1, KIND_AUDIO, 8'hFF, 1'b0),
      // count already sits at the new interval: a zero length byte restarts it
      reg_row(REG_INTERVAL, 16'd2),
      fixed_row(8'h00, 1'b0, KIND_NONE, 8'h00, 1'b0),
      byte_row(8'h7E, 1'b0, 5'd2),
      // one unit of metadata, printable edges, closed by a control byte
      byte_row(8'h01, 1'b1, 5'd1),
      byte_row(8'h20, 1'b0, 5'd1),
      byte_row(8'h1F, 1'b0, 5'd1),
      byte_row(8'h7F, 1'b1, 5'd1),
      byte_row(8'h7E, 1'b0, 5'd12),
      fixed_row(8'h0D, 1'b0, KIND_META_END, 8'h00, 1'b1),
      // header: junk status line, repeated CR, lone LF as content, blank line
      reg_row(REG_SKIP, 16'd1),
      fixed_row(8'h58, 1'b0, KIND_NONE, 8'h00, 1'b0),
      byte_row(CH_CR, 1'b0, 5'd2),
      fixed_row(CH_LF, 1'b1, KIND_NONE, 8'h00, 1'b0),
      fixed_row(8'h41, 1'b0, KIND_NONE, 8'h00, 1'b0),
      fixed_row(CH_LF, 1'b0, KIND_NONE, 8'h00, 1'b0),
      byte_row(CH_CR, 1'b0, 5'd1),
      fixed_row(CH_LF, 1'b0, KIND_NONE, 8'h00, 1'b0),
      byte_row(CH_CR, 1'b0, 5'd1),
      fixed_row(CH_LF, 1'b0, KIND_NONE, 8'h00, 1'b0),
      // terminating LF is consumed, so this one is audio
      fixed_row(CH_LF, 1'b0, KIND_AUDIO, CH_LF, 1'b0),
      reg_row(REG_SKIP, 16'd0)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed steps
    foreach (plan[i]) begin
      if (plan[i].wr) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        repeat (plan[i].reps) send_byte(plan[i].b, plan[i].ce, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < NPHASE; p++) begin
      write_reg(REG_INTERVAL, ph_interval[p]);
      write_reg(REG_SKIP, CFG_DATA_W'(ph_skip[p]));
      want_big = (p == 5);
      if (!hdr_done) send_header();

      // interval lowered below the count: keep counting audio at full rate,
      // then meet the count with the interval to close a block
      if (meta_interval != 0 && audio_cnt > meta_interval) begin
        idle_pct = 0;
        repeat (WRAP_ITEMS) send_byte(BYTE_W'($urandom_range(255)), chunk_mark());
        idle_pct = 30;
        write_reg(REG_INTERVAL, audio_cnt);
        while (!(meta_left == 0 && audio_cnt == 0)) send_body_byte();
        write_reg(REG_INTERVAL, ph_interval[p]);
      end

      // end each phase on a block boundary so the next interval is not undercut
      body_n = 0;
      while (body_n < PHASE_ITEMS ||
             !(meta_left == 0 && (audio_cnt == 0 || meta_interval == 0 ||
                                  meta_interval == 16'hFFFF))) begin
        send_body_byte();
        body_n++;
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
